// File: hdl/v3an_pkg.sv
// shared widths, operation codes, pipeline payload types and fixed-point helpers
// for the vector3 alu / normalize unit; no dependencies
package v3an_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int MAG_W       = DATA_W - 1;
   localparam int LANES       = 3;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int NUM_W       = DATA_W + FRAC_BITS + 1;
   localparam int SQRT_STEPS  = PROD_W / 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_SUB    = 3'd1;
   localparam logic [2:0] OP_SCALE  = 3'd2;
   localparam logic [2:0] OP_DIV    = 3'd3;
   localparam logic [2:0] OP_LENGTH = 3'd4;
   localparam logic [2:0] OP_NORM   = 3'd5;

   localparam logic [NUM_W-1:0] POS_LIMIT = NUM_W'((64'd1 << (DATA_W - 1)) - 64'd1);
   localparam logic [NUM_W-1:0] NEG_LIMIT = NUM_W'(64'd1 << (DATA_W - 1));
   localparam logic [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_ADD,
      KIND_SUB,
      KIND_SCALE,
      KIND_DIV,
      KIND_LENGTH,
      KIND_NORM
   } kind_type;

   typedef logic [LANES-1:0][DATA_W-1:0] vec_type;
   typedef logic [LANES-1:0][NUM_W-1:0]  num_vec_type;

   // classified transaction as it sits in the queue
   typedef struct packed {
      kind_type            kind;
      vec_type             a;
      vec_type             b;
      vec_type             a_mag;
      logic [LANES-1:0]    a_neg;
      logic [DATA_W-1:0]   s_mag;
      logic                s_neg;
      logic                s_zero;
   } item_type;

   // payload carried through the product and square root stages
   typedef struct packed {
      kind_type            kind;
      vec_type             vec;
      vec_type             a_mag;
      logic [LANES-1:0]    a_neg;
      logic [DATA_W-1:0]   s_mag;
      logic                s_neg;
      logic                s_zero;
   } carry_type;

   // payload carried alongside the divider
   typedef struct packed {
      kind_type            kind;
      vec_type             vec;
      logic [MAG_W-1:0]    magnitude;
      logic                fault;
      logic [LANES-1:0]    neg;
   } div_tag_type;

   function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      r = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
      return r;
   endfunction

   // apply sign to an unsigned magnitude and clamp to the signed word range
   function automatic logic [DATA_W-1:0] sat_signed(input logic [NUM_W-1:0] m,
                                                    input logic neg);
      logic [DATA_W-1:0] r;
      if (neg) begin
         if (m > NEG_LIMIT) r = WORD_MIN;
         else               r = ~m[DATA_W-1:0] + DATA_W'(1);
      end else begin
         if (m > POS_LIMIT) r = WORD_MAX;
         else               r = m[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hdl/v3an_front.sv
// front end: decodes the operation code and splits the a operands and the scalar into sign and magnitude
// depends on v3an_pkg
module v3an_front import v3an_pkg::*; (
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_a_x,
   input  logic signed [DATA_W-1:0] req_a_y,
   input  logic signed [DATA_W-1:0] req_a_z,
   input  logic signed [DATA_W-1:0] req_b_x,
   input  logic signed [DATA_W-1:0] req_b_y,
   input  logic signed [DATA_W-1:0] req_b_z,
   input  logic signed [DATA_W-1:0] req_scalar,
   input  logic                     queue_full,
   output logic                     push,
   output item_type                 item
);

   kind_type kind;

   always_comb begin
      unique case (req_operation)
         OP_ADD:    kind = KIND_ADD;
         OP_SUB:    kind = KIND_SUB;
         OP_SCALE:  kind = KIND_SCALE;
         OP_DIV:    kind = KIND_DIV;
         OP_LENGTH: kind = KIND_LENGTH;
         OP_NORM:   kind = KIND_NORM;
         default:   kind = KIND_NONE;
      endcase
   end

   always_comb begin
      item.kind   = kind;
      item.a[0]   = req_a_x;
      item.a[1]   = req_a_y;
      item.a[2]   = req_a_z;
      item.b[0]   = req_b_x;
      item.b[1]   = req_b_y;
      item.b[2]   = req_b_z;
      for (int i = 0; i < LANES; i++) begin
         item.a_mag[i] = mag_of(item.a[i]);
         item.a_neg[i] = item.a[i][DATA_W-1];
      end
      item.s_mag  = mag_of(req_scalar);
      item.s_neg  = req_scalar[DATA_W-1];
      item.s_zero = (req_scalar == '0);
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

// File: hdl/v3an_queue.sv
// short queue that decouples the front end from the arithmetic pipeline
// depends on v3an_pkg
module v3an_queue import v3an_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/v3an_div.sv
// pipelined restoring divider, one quotient bit per stage, three lanes sharing a divisor
// depends on v3an_pkg
module v3an_div import v3an_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  num_vec_type       in_num,
   input  logic [DATA_W-1:0] in_den,
   input  div_tag_type       in_tag,
   output logic              out_valid,
   output num_vec_type       out_quot,
   output div_tag_type       out_tag
);

   logic              v_ff   [NUM_W];
   vec_type           rem_ff [NUM_W];
   vec_type           rem_in [NUM_W];
   num_vec_type       nq_ff  [NUM_W];
   num_vec_type       nq_in  [NUM_W];
   logic [DATA_W-1:0] den_ff [NUM_W];
   logic [DATA_W-1:0] den_src[NUM_W];
   div_tag_type       tag_ff [NUM_W];
   div_tag_type       tag_src[NUM_W];
   logic              v_src  [NUM_W];

   // numerator bits leave at the top of nq while quotient bits enter at the bottom
   always_comb begin
      logic [DATA_W:0]   rem_sh;
      logic [DATA_W-1:0] rem_cur;
      logic [NUM_W-1:0]  nq_cur;
      logic              ge;
      for (int k = 0; k < NUM_W; k++) begin
         if (k == 0) begin
            v_src[k]   = in_valid;
            den_src[k] = in_den;
            tag_src[k] = in_tag;
         end else begin
            v_src[k]   = v_ff[k-1];
            den_src[k] = den_ff[k-1];
            tag_src[k] = tag_ff[k-1];
         end
         for (int i = 0; i < LANES; i++) begin
            if (k == 0) begin
               rem_cur = '0;
               nq_cur  = in_num[i];
            end else begin
               rem_cur = rem_ff[k-1][i];
               nq_cur  = nq_ff[k-1][i];
            end
            rem_sh = {rem_cur, nq_cur[NUM_W-1]};
            ge     = (rem_sh >= {1'b0, den_src[k]});
            if (ge) rem_in[k][i] = DATA_W'(rem_sh - {1'b0, den_src[k]});
            else    rem_in[k][i] = rem_sh[DATA_W-1:0];
            nq_in[k][i] = {nq_cur[NUM_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_W; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < NUM_W; k++) v_ff[k] <= v_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_W; k++) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k]  <= nq_in[k];
            den_ff[k] <= den_src[k];
            tag_ff[k] <= tag_src[k];
         end
      end
   end

   assign out_valid = v_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_tag   = tag_ff[NUM_W-1];

endmodule

// File: hdl/v3an_back.sv
// back end: products, sum of squares, pipelined square root, divider and output register
// depends on v3an_pkg and v3an_div
module v3an_back import v3an_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  item_type          in_item,
   output logic              in_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vec_type           rsp_vec,
   output logic [MAG_W-1:0]  rsp_magnitude,
   output logic              rsp_fault
);

   logic en;

   // stage 1: add/sub and the three multipliers
   logic                          s1_valid_ff;
   carry_type                     s1_carry_ff, s1_carry_in;
   logic [LANES-1:0][PROD_W-1:0]  s1_prod_ff, s1_prod_in;

   // stage 2: scale rounding and sum of squares
   logic                          s2_valid_ff;
   carry_type                     s2_carry_ff, s2_carry_in;
   logic [PROD_W-1:0]             s2_sumsq_ff, s2_sumsq_in;

   // square root, one result bit per stage
   logic                          sq_valid_ff [SQRT_STEPS];
   logic                          sq_valid_in [SQRT_STEPS];
   logic [PROD_W-1:0]             sq_x_ff     [SQRT_STEPS];
   logic [PROD_W-1:0]             sq_x_in     [SQRT_STEPS];
   logic [PROD_W-1:0]             sq_res_ff   [SQRT_STEPS];
   logic [PROD_W-1:0]             sq_res_in   [SQRT_STEPS];
   carry_type                     sq_carry_ff [SQRT_STEPS];
   carry_type                     sq_carry_in [SQRT_STEPS];

   // stage 3: divider operand setup
   logic                          s3_valid_ff;
   num_vec_type                   s3_num_ff, s3_num_in;
   logic [DATA_W-1:0]             s3_den_ff, s3_den_in;
   div_tag_type                   s3_tag_ff, s3_tag_in;

   logic                          div_valid;
   num_vec_type                   div_quot;
   div_tag_type                   div_tag;

   logic                          rsp_valid_ff;
   vec_type                       rsp_vec_ff, rsp_vec_in;
   logic [MAG_W-1:0]              rsp_mag_ff;
   logic                          rsp_fault_ff;

   // whole pipeline moves in lockstep whenever the output register can take a result
   assign en     = !rsp_valid_ff || rsp_ready;
   assign in_pop = en && in_valid;

   always_comb begin
      logic [DATA_W:0]   ext_a, ext_b, sum;
      logic [DATA_W-1:0] opnd;
      s1_carry_in.kind   = in_item.kind;
      s1_carry_in.a_mag  = in_item.a_mag;
      s1_carry_in.a_neg  = in_item.a_neg;
      s1_carry_in.s_mag  = in_item.s_mag;
      s1_carry_in.s_neg  = in_item.s_neg;
      s1_carry_in.s_zero = in_item.s_zero;
      for (int i = 0; i < LANES; i++) begin
         ext_a = {in_item.a[i][DATA_W-1], in_item.a[i]};
         ext_b = {in_item.b[i][DATA_W-1], in_item.b[i]};
         sum   = (in_item.kind == KIND_SUB) ? ext_a - ext_b : ext_a + ext_b;
         if (in_item.kind != KIND_ADD && in_item.kind != KIND_SUB)
            s1_carry_in.vec[i] = '0;
         else if (sum[DATA_W] != sum[DATA_W-1])
            s1_carry_in.vec[i] = sum[DATA_W] ? WORD_MIN : WORD_MAX;
         else
            s1_carry_in.vec[i] = sum[DATA_W-1:0];
         // scale multiplies by the scalar, every other kind squares the component (used by length and normalize)
         opnd = (in_item.kind == KIND_SCALE) ? in_item.s_mag : in_item.a_mag[i];
         s1_prod_in[i] = in_item.a_mag[i] * opnd;
      end
   end

   always_comb begin
      logic [PROD_W-1:0] rnd;
      s2_carry_in = s1_carry_ff;
      for (int i = 0; i < LANES; i++) begin
         rnd = s1_prod_ff[i] + (PROD_W'(1) << (FRAC_BITS - 1));
         if (s1_carry_ff.kind == KIND_SCALE) begin
            s2_carry_in.vec[i] = sat_signed(NUM_W'(rnd >> FRAC_BITS),
                                            s1_carry_ff.a_neg[i] ^ s1_carry_ff.s_neg);
         end
      end
      s2_sumsq_in = s1_prod_ff[0] + s1_prod_ff[1] + s1_prod_ff[2];
   end

   always_comb begin
      logic [PROD_W-1:0] x_cur, res_cur, bit_val, trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            sq_valid_in[k] = s2_valid_ff;
            sq_carry_in[k] = s2_carry_ff;
            x_cur          = s2_sumsq_ff;
            res_cur        = '0;
         end else begin
            sq_valid_in[k] = sq_valid_ff[k-1];
            sq_carry_in[k] = sq_carry_ff[k-1];
            x_cur          = sq_x_ff[k-1];
            res_cur        = sq_res_ff[k-1];
         end
         bit_val = PROD_W'(1) << (PROD_W - 2 - 2 * k);
         trial   = res_cur + bit_val;
         if (x_cur >= trial) begin
            sq_x_in[k]   = x_cur - trial;
            sq_res_in[k] = (res_cur >> 1) + bit_val;
         end else begin
            sq_x_in[k]   = x_cur;
            sq_res_in[k] = res_cur >> 1;
         end
      end
   end

   always_comb begin
      carry_type         c;
      logic [DATA_W-1:0] len;
      logic              len_zero;
      logic [MAG_W-1:0]  len_sat;
      c        = sq_carry_ff[SQRT_STEPS-1];
      len      = sq_res_ff[SQRT_STEPS-1][DATA_W-1:0];
      len_zero = (len == '0);
      len_sat  = len[DATA_W-1] ? '1 : len[MAG_W-1:0];
      s3_tag_in.kind      = c.kind;
      s3_tag_in.vec       = c.vec;
      s3_tag_in.magnitude = '0;
      s3_tag_in.fault     = 1'b0;
      s3_tag_in.neg       = c.a_neg;
      s3_den_in           = DATA_W'(1);
      unique case (c.kind)
         KIND_DIV: begin
            s3_tag_in.fault = c.s_zero;
            s3_tag_in.neg   = c.a_neg ^ {LANES{c.s_neg}};
            if (!c.s_zero) s3_den_in = c.s_mag;
         end
         KIND_LENGTH: begin
            s3_tag_in.magnitude = len_sat;
         end
         KIND_NORM: begin
            s3_tag_in.fault = len_zero;
            if (!len_zero) begin
               s3_tag_in.magnitude = len_sat;
               s3_den_in           = len;
            end
         end
         default: begin
         end
      endcase
      // round to nearest: add half the divisor before dividing
      for (int i = 0; i < LANES; i++) begin
         s3_num_in[i] = NUM_W'({c.a_mag[i], {FRAC_BITS{1'b0}}}) + NUM_W'(s3_den_in >> 1);
      end
   end

   v3an_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_tag    (s3_tag_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   always_comb begin
      logic use_quot;
      use_quot = (div_tag.kind == KIND_DIV || div_tag.kind == KIND_NORM) && !div_tag.fault;
      for (int i = 0; i < LANES; i++) begin
         if (use_quot)          rsp_vec_in[i] = sat_signed(div_quot[i], div_tag.neg[i]);
         else if (div_tag.fault) rsp_vec_in[i] = '0;
         else                   rsp_vec_in[i] = div_tag.vec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < SQRT_STEPS; k++) sq_valid_ff[k] <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= sq_valid_ff[SQRT_STEPS-1];
         rsp_valid_ff <= div_valid;
         for (int k = 0; k < SQRT_STEPS; k++) sq_valid_ff[k] <= sq_valid_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_carry_ff  <= s1_carry_in;
         s1_prod_ff   <= s1_prod_in;
         s2_carry_ff  <= s2_carry_in;
         s2_sumsq_ff  <= s2_sumsq_in;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_x_ff[k]     <= sq_x_in[k];
            sq_res_ff[k]   <= sq_res_in[k];
            sq_carry_ff[k] <= sq_carry_in[k];
         end
         s3_num_ff    <= s3_num_in;
         s3_den_ff    <= s3_den_in;
         s3_tag_ff    <= s3_tag_in;
         rsp_vec_ff   <= rsp_vec_in;
         rsp_mag_ff   <= div_tag.magnitude;
         rsp_fault_ff <= div_tag.fault;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vec       = rsp_vec_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_fault     = rsp_fault_ff;

endmodule

// File: hdl/vector3_alu_normalize_unit.sv
// top level of the vector3 alu / normalize unit: front end, queue and arithmetic back end
// depends on v3an_pkg, v3an_front, v3an_queue, v3an_back
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_ready  operation, a_x..a_z, b_x..b_z, scalar
//   rsp_      out         rsp_valid / rsp_ready  r_x, r_y, r_z, magnitude, fault
//
// one transaction per cycle sustained while rsp_ready keeps the output register free
// the back end holds the 32-stage square root and the 49-stage divider, one bit per stage
// the back end advances in lockstep and holds while a result waits in the output register
// a four-entry queue keeps req_ready high during such a stall until it holds four transactions
// synchronous reset clears control state only; no clearing pass is needed
module vector3_alu_normalize_unit import v3an_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_a_x,
   input  logic signed [DATA_W-1:0] req_a_y,
   input  logic signed [DATA_W-1:0] req_a_z,
   input  logic signed [DATA_W-1:0] req_b_x,
   input  logic signed [DATA_W-1:0] req_b_y,
   input  logic signed [DATA_W-1:0] req_b_z,
   input  logic signed [DATA_W-1:0] req_scalar,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_r_x,
   output logic signed [DATA_W-1:0] rsp_r_y,
   output logic signed [DATA_W-1:0] rsp_r_z,
   output logic [MAG_W-1:0]         rsp_magnitude,
   output logic                     rsp_fault
);

   logic     queue_full;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     not_empty;
   item_type head_item;
   vec_type  rsp_vec;

   v3an_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_a_x       (req_a_x),
      .req_a_y       (req_a_y),
      .req_a_z       (req_a_z),
      .req_b_x       (req_b_x),
      .req_b_y       (req_b_y),
      .req_b_z       (req_b_z),
      .req_scalar    (req_scalar),
      .queue_full    (queue_full),
      .push          (push),
      .item          (push_item)
   );

   v3an_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   v3an_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (not_empty),
      .in_item       (head_item),
      .in_pop        (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_vec       (rsp_vec),
      .rsp_magnitude (rsp_magnitude),
      .rsp_fault     (rsp_fault)
   );

   assign rsp_r_x = $signed(rsp_vec[0]);
   assign rsp_r_y = $signed(rsp_vec[1]);
   assign rsp_r_z = $signed(rsp_vec[2]);

endmodule
